// ===== hw/rtl/credential_slot_table_unit_macros.svh =====
// Assertion macros used by the credential slot table checker.
`ifndef CREDENTIAL_SLOT_TABLE_UNIT_MACROS_SVH
`define CREDENTIAL_SLOT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("credential slot table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("credential slot table: next-cycle check failed");

`endif

// ===== hw/rtl/cst_pkg.sv =====
// Shared constants, codes and types of the credential slot table.
package cst_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int ID_W         = 10;
    localparam int HASH_W       = 64;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 3;
    localparam int ID_LIMIT     = 1 << ID_W;
    // Highest addressable slot plus one: slot_id cannot reach beyond ID_LIMIT.
    localparam int SEARCH_LIMIT = (TABLE_DEPTH < ID_LIMIT) ? TABLE_DEPTH : ID_LIMIT;
    localparam int ROW_BITS     = 32;
    localparam int BIT_W        = 5;
    localparam int MAP_ROWS     = (SEARCH_LIMIT + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W        = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
    localparam int HADDR_W      = $clog2(SEARCH_LIMIT);

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 3'd0,
        OP_DELETE = 3'd1,
        OP_LOGIN  = 3'd2,
        OP_LOGOUT = 3'd3,
        OP_CHANGE = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_CREATE,
        K_DELETE,
        K_LOGIN,
        K_LOGOUT,
        K_CHANGE,
        K_REJECT
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_NONE    = 3'd2,
        ST_BADHASH = 3'd3,
        ST_ONLINE  = 3'd4,
        ST_OFFLINE = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EXEC
    } t_back_state;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   slot_id;
        logic [HASH_W-1:0] key_hash;
        logic [HASH_W-1:0] repl_hash;
    } t_cmd;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

// ===== hw/rtl/cst_front.sv =====
// Front end: accepts request words, classifies them and queues them for the back end.
module cst_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [cst_pkg::OP_W-1:0]   i_operation,
    input  logic [cst_pkg::ID_W-1:0]   i_slot_id,
    input  logic [cst_pkg::HASH_W-1:0] i_key_hash,
    input  logic [cst_pkg::HASH_W-1:0] i_repl_hash,
    input  cst_pkg::t_back_ctl       i_ctl,
    output logic                     o_cmd_valid,
    output cst_pkg::t_cmd            o_cmd
);
    import cst_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    t_cmd              r_q [QDEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              id_ok;
    t_kind             kind;
    t_cmd              cmd_in;

    // Slot zero is reserved and slots beyond the table do not exist.
    assign id_ok = (i_slot_id != '0) &&
                   ({1'b0, i_slot_id} < (ID_W + 1)'(SEARCH_LIMIT));

    always_comb begin
        unique case (i_operation)
            OP_CREATE: kind = K_CREATE;
            OP_DELETE: kind = K_DELETE;
            OP_LOGIN:  kind = K_LOGIN;
            OP_LOGOUT: kind = K_LOGOUT;
            OP_CHANGE: kind = K_CHANGE;
            default:   kind = K_REJECT;
        endcase
        if (kind != K_CREATE && !id_ok) begin
            kind = K_REJECT;
        end
        cmd_in.kind      = kind;
        cmd_in.slot_id   = i_slot_id;
        cmd_in.key_hash  = i_key_hash;
        cmd_in.repl_hash = i_repl_hash;
    end

    assign o_stall     = (r_count == QCNT_W'(QDEPTH)) || i_ctl.clearing;
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !i_ctl.pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_ctl.pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ===== hw/rtl/cst_back.sv =====
// Back end: slot memories, free-slot search, request execution and result register.
module cst_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  cst_pkg::t_cmd              i_cmd,
    output cst_pkg::t_back_ctl         o_ctl,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cst_pkg::STATUS_W-1:0] o_status,
    output logic [cst_pkg::ID_W-1:0]     o_assigned_id
);
    import cst_pkg::*;

    // Marks slot zero and slots beyond the table as permanently taken.
    function automatic logic [ROW_BITS-1:0] reserved_mask(input logic [ROW_W-1:0] row);
        logic [ROW_BITS-1:0] mask;
        int                  slot;
        for (int b = 0; b < ROW_BITS; b++) begin
            slot    = int'(row) * ROW_BITS + b;
            mask[b] = (slot == 0) || (slot >= SEARCH_LIMIT);
        end
        return mask;
    endfunction

    t_back_state         r_state, n_state;
    logic [ROW_W-1:0]    r_clr_row, n_clr_row;
    logic [MAP_ROWS-1:0] r_full, n_full;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [ID_W-1:0]     r_out_id, n_out_id;
    t_cmd                r_cmd;
    logic [ROW_W-1:0]    r_row, n_row;
    logic                r_none_free, n_none_free;
    logic                load_cmd;

    logic [ROW_BITS-1:0] r_valid_map  [MAP_ROWS];
    logic [ROW_BITS-1:0] r_online_map [MAP_ROWS];
    logic [HASH_W-1:0]   r_hash_mem   [SEARCH_LIMIT];
    logic [ROW_BITS-1:0] r_valid_rd;
    logic [ROW_BITS-1:0] r_online_rd;
    logic [HASH_W-1:0]   r_hash_rd;

    logic                map_we;
    logic [ROW_W-1:0]    map_wa;
    logic [ROW_W-1:0]    map_ra;
    logic [ROW_BITS-1:0] valid_wd;
    logic [ROW_BITS-1:0] online_wd;
    logic                hash_we;
    logic [HADDR_W-1:0]  hash_wa;
    logic [HADDR_W-1:0]  hash_ra;
    logic [HASH_W-1:0]   hash_wd;

    logic [ROW_W-1:0]    free_row;
    logic                any_free;
    logic [BIT_W-1:0]    free_bit;
    logic [BIT_W-1:0]    ex_bit;
    logic [ROW_BITS-1:0] free_mask;
    logic [ROW_BITS-1:0] ex_mask;
    logic [ROW_BITS-1:0] grown_row;
    logic                ex_hit;
    logic                ex_match;
    logic                ex_online;
    logic                out_free;

    // Lowest row that still has a free slot.
    always_comb begin
        free_row = '0;
        any_free = 1'b0;
        for (int r = MAP_ROWS - 1; r >= 0; r--) begin
            if (!r_full[r]) begin
                free_row = ROW_W'(r);
                any_free = 1'b1;
            end
        end
    end

    // Lowest free slot within the row just read.
    always_comb begin
        free_bit = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (!r_valid_rd[b]) begin
                free_bit = BIT_W'(b);
            end
        end
    end

    assign ex_bit    = r_cmd.slot_id[BIT_W-1:0];
    assign free_mask = ROW_BITS'(1) << free_bit;
    assign ex_mask   = ROW_BITS'(1) << ex_bit;
    assign grown_row = r_valid_rd | free_mask;
    assign ex_hit    = r_valid_rd[ex_bit];
    assign ex_match  = (r_hash_rd == r_cmd.key_hash);
    assign ex_online = r_online_rd[ex_bit];
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_clr_row    = r_clr_row;
        n_full       = r_full;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_row        = r_row;
        n_none_free  = r_none_free;
        load_cmd     = 1'b0;
        o_ctl.pop      = 1'b0;
        o_ctl.clearing = 1'b0;
        map_we       = 1'b0;
        map_wa       = r_row;
        map_ra       = r_row;
        valid_wd     = r_valid_rd;
        online_wd    = r_online_rd;
        hash_we      = 1'b0;
        hash_wa      = r_cmd.slot_id[HADDR_W-1:0];
        hash_ra      = r_cmd.slot_id[HADDR_W-1:0];
        hash_wd      = r_cmd.repl_hash;

        unique case (r_state)
            BS_CLEAR: begin
                o_ctl.clearing = 1'b1;
                map_we         = 1'b1;
                map_wa         = r_clr_row;
                valid_wd       = reserved_mask(r_clr_row);
                online_wd      = '0;
                if (r_clr_row == ROW_W'(MAP_ROWS - 1)) begin
                    n_state = BS_IDLE;
                end else begin
                    n_clr_row = r_clr_row + 1'b1;
                end
            end
            BS_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_ctl.pop   = 1'b1;
                    load_cmd    = 1'b1;
                    n_none_free = !any_free;
                    n_row       = (i_cmd.kind == K_CREATE) ? free_row
                                : i_cmd.slot_id[ROW_W+BIT_W-1:BIT_W];
                    map_ra      = n_row;
                    hash_ra     = i_cmd.slot_id[HADDR_W-1:0];
                    n_state     = BS_EXEC;
                end
            end
            BS_EXEC: begin
                n_state      = BS_IDLE;
                n_out_valid  = 1'b1;
                n_out_id     = '0;
                n_out_status = ST_NONE;
                priority if (r_cmd.kind == K_REJECT) begin
                    n_out_status = ST_NONE;
                end else if (r_cmd.kind == K_CREATE) begin
                    if (r_none_free) begin
                        n_out_status = ST_FULL;
                    end else begin
                        map_we        = 1'b1;
                        valid_wd      = grown_row;
                        online_wd     = r_online_rd & ~free_mask;
                        hash_we       = 1'b1;
                        hash_wa       = HADDR_W'({r_row, free_bit});
                        hash_wd       = r_cmd.key_hash;
                        n_full[r_row] = &grown_row;
                        n_out_status  = ST_OK;
                        n_out_id      = ID_W'({r_row, free_bit});
                    end
                end else if (!ex_hit) begin
                    n_out_status = ST_NONE;
                end else if (!ex_match) begin
                    n_out_status = ST_BADHASH;
                end else begin
                    unique case (r_cmd.kind)
                        K_DELETE: begin
                            map_we        = 1'b1;
                            valid_wd      = r_valid_rd & ~ex_mask;
                            online_wd     = r_online_rd & ~ex_mask;
                            n_full[r_row] = 1'b0;
                            n_out_status  = ST_OK;
                        end
                        K_LOGIN: begin
                            if (ex_online) begin
                                n_out_status = ST_ONLINE;
                            end else begin
                                map_we       = 1'b1;
                                online_wd    = r_online_rd | ex_mask;
                                n_out_status = ST_OK;
                            end
                        end
                        K_LOGOUT: begin
                            if (!ex_online) begin
                                n_out_status = ST_OFFLINE;
                            end else begin
                                map_we       = 1'b1;
                                online_wd    = r_online_rd & ~ex_mask;
                                n_out_status = ST_OK;
                            end
                        end
                        K_CHANGE: begin
                            hash_we      = 1'b1;
                            n_out_status = ST_OK;
                        end
                        default: begin
                            n_out_status = ST_NONE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = BS_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_CLEAR;
            r_clr_row   <= '0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_row        <= n_row;
        r_none_free  <= n_none_free;
        if (load_cmd) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_valid_map[map_wa]  <= valid_wd;
            r_online_map[map_wa] <= online_wd;
        end
        r_valid_rd  <= r_valid_map[map_ra];
        r_online_rd <= r_online_map[map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hash_we) begin
            r_hash_mem[hash_wa] <= hash_wd;
        end
        r_hash_rd <= r_hash_mem[hash_ra];
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_assigned_id = r_out_id;

endmodule

// ===== hw/rtl/credential_slot_table_unit.sv =====
// Top level of the credential slot table: front end, request queue and back end.
//
// The unit keeps a table of 1024 credential slots, each with a 64-bit hash, a valid mark and
// an online mark, and answers every request word with exactly one result word. A request
// passes through the back end's idle and execute states: the idle state reads the slot's hash
// and the row of valid and online marks that holds it, and the execute state compares, updates
// the memories and loads the result register, so the back end takes no new word before it is
// through with the last; the single read and write port of the hash and mark memories is why.
// The front end classifies each word and holds up to two of them in a queue, so input words
// are still taken while a result waits on a stalled output. Create finds the lowest free slot
// through a register of per-row full flags followed by a search of the one row it reads, which
// is why slot 0 and any slot past the table are kept permanently marked as taken. After reset
// the unit clears its valid and online marks one row of 32 slots per cycle, 32 rows in all, and
// holds o_stall high until that pass is complete. Hashes are never cleared: their value is
// used only for slots that a create has written.
module credential_slot_table_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [cst_pkg::OP_W-1:0]     i_operation,
    input  logic [cst_pkg::ID_W-1:0]     i_slot_id,
    input  logic [cst_pkg::HASH_W-1:0]   i_key_hash,
    input  logic [cst_pkg::HASH_W-1:0]   i_repl_hash,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [cst_pkg::STATUS_W-1:0] o_status,
    output logic [cst_pkg::ID_W-1:0]     o_assigned_id
);
    import cst_pkg::*;

    // Queue head and the back end's pop and clearing flags.
    t_cmd      cmd;
    logic      cmd_valid;
    t_back_ctl ctl;

    // The front end turns unknown operations and unusable slot numbers into a single
    // reject class, so the back end only has to answer "no such slot" for them.
    cst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_slot_id   (i_slot_id),
        .i_key_hash  (i_key_hash),
        .i_repl_hash (i_repl_hash),
        .i_ctl       (ctl),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // The back end pops a word only when its result register will be free, so a stalled
    // result never blocks the front end from filling the queue.
    cst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_ctl         (ctl),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_assigned_id (o_assigned_id)
    );

endmodule

// ===== hw/rtl/cst_checker.sv =====
// Port-level checks of the credential slot table, bound to its top level.
`include "credential_slot_table_unit_macros.svh"

module cst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [cst_pkg::STATUS_W-1:0] o_status,
    input logic [cst_pkg::ID_W-1:0]     o_assigned_id
);
    import cst_pkg::*;

    // A result word held by a stall keeps its contents.
    `CST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_assigned_id))

    // Only the defined status codes appear.
    `CST_ASSERT_HOLDS(a_status_range, i_clk, i_rst_n, o_valid, o_status <= STATUS_W'(ST_OFFLINE))

    // A slot number is handed out only with a successful result.
    `CST_ASSERT_HOLDS(a_id_only_ok, i_clk, i_rst_n, o_valid && (o_assigned_id != '0), o_status == ST_OK)

endmodule

bind credential_slot_table_unit cst_checker u_cst_checker (.*);
